// ===== hdl/efsd_pkg.sv =====
// Package for the earliest-free server dispatch unit: field widths,
// configuration register indexes and the controller command bundle.
// No dependencies; every other file of the block but efsd_ram imports it.
package efsd_pkg;

   localparam int TIME_W     = 32;
   localparam int DUR_W      = 16;
   localparam int ACT_W      = 5;
   localparam int WAIT_W     = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [ACT_W-1:0]  ACTIVE_RESET = ACT_W'(1);
   localparam logic [WAIT_W-1:0] WAIT_RESET   = WAIT_W'(20);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ACTIVE_SERVERS = 2'd0,
      CSR_WAIT_LIMIT     = 2'd1
   } csr_index_type;

   // Controller to datapath commands
   typedef struct packed {
      logic load;    // capture the incoming job beat
      logic rd_en;   // read one free-at entry
      logic calc;    // form start time and late flag
      logic commit;  // write back free-at, update count, load result
   } ctrl_cmd_type;

endpackage

// ===== hdl/efsd_req_if.sv =====
// Job channel: valid/ready handshake with arrival time and duration.
// Depends on efsd_pkg.
interface efsd_req_if;
   import efsd_pkg::*;

   logic                valid;
   logic                ready;
   logic [TIME_W-1:0]   arrival_time;
   logic [DUR_W-1:0]    service_duration;

   modport source (output valid, output arrival_time, output service_duration, input ready);
   modport sink   (input valid, input arrival_time, input service_duration, output ready);
endinterface

// ===== hdl/efsd_rsp_if.sv =====
// Result channel: valid/ready handshake with start time, late flag and count.
// Depends on efsd_pkg.
interface efsd_rsp_if;
   import efsd_pkg::*;

   logic                valid;
   logic                ready;
   logic [TIME_W-1:0]   start_time;
   logic                late_flag;
   logic [TIME_W-1:0]   late_total;

   modport source (output valid, output start_time, output late_flag, output late_total,
                   input ready);
   modport sink   (input valid, input start_time, input late_flag, input late_total,
                   output ready);
endinterface

// ===== hdl/earliest_free_server_dispatch_unit.sv =====
// Earliest-free server dispatch unit. Each job beat on req_ch carries an
// arrival time and a service duration; the unit picks the active server with
// the smallest free-at time (lowest index on a tie), starts the job at the
// later of arrival and that time, and moves the server's free-at time to
// start plus duration, saturating at the top of the 32-bit range. A job is
// late when the chosen free-at time exceeds arrival plus wait_limit; late
// jobs bump a saturating count. One result beat leaves on rsp_ch per job.
// A job runs from acceptance to the next acceptance in these steps: the scan
// reads the free-at RAM one server per cycle through its single read port,
// over active_servers clamped to 1..MAX_SERVERS; a drain state lets the last
// read land, a calc state forms the start time and late test, and a commit
// state writes back. The result sits in an output register, so the next job is taken
// while it waits; write-back stalls only if that register is still full.
// Free-at entries carry valid bits cleared at reset, so there is no clearing
// pass. Write configuration only while the unit is idle.
// Depends on efsd_pkg, efsd_req_if, efsd_rsp_if, efsd_ctrl and efsd_dpath.
module earliest_free_server_dispatch_unit #(
   parameter int MAX_SERVERS = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   efsd_req_if.sink                         req_ch,
   efsd_rsp_if.source                       rsp_ch,
   input  logic                             csr_wr_en,
   input  logic [efsd_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [efsd_pkg::CSR_DATA_W-1:0]  csr_wr_data
);
   import efsd_pkg::*;

   localparam int IDX_W = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;

   logic [ACT_W-1:0]  active_servers_ff, active_servers_in;
   logic [WAIT_W-1:0] wait_limit_ff, wait_limit_in;

   ctrl_cmd_type      cmd;
   logic [IDX_W-1:0]  rd_addr;
   logic              out_free;
   logic              req_ready;

   // Register file: unknown indexes drop the write
   always_comb begin
      active_servers_in = active_servers_ff;
      wait_limit_in     = wait_limit_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_ACTIVE_SERVERS: active_servers_in = csr_wr_data[ACT_W-1:0];
            CSR_WAIT_LIMIT:     wait_limit_in     = csr_wr_data[WAIT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_servers_ff <= ACTIVE_RESET;
         wait_limit_ff     <= WAIT_RESET;
      end else begin
         active_servers_ff <= active_servers_in;
         wait_limit_ff     <= wait_limit_in;
      end
   end

   assign req_ch.ready = req_ready;

   // Sequencer: accept, scan, calculate, write back
   efsd_ctrl #(
      .MAX_SERVERS (MAX_SERVERS)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_ch.valid),
      .req_ready      (req_ready),
      .active_servers (active_servers_ff),
      .out_free       (out_free),
      .cmd            (cmd),
      .rd_addr        (rd_addr)
   );

   // Free-at store, minimum search and result register
   efsd_dpath #(
      .MAX_SERVERS (MAX_SERVERS)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req        (req_ch),
      .rsp        (rsp_ch),
      .wait_limit (wait_limit_ff),
      .cmd        (cmd),
      .rd_addr    (rd_addr),
      .out_free   (out_free)
   );

   a_cmd_exclusive: assert property (@(posedge clock) disable iff (reset)
      $countones(cmd) <= 1)
      else $error("more than one datapath command in a cycle");
endmodule

// ===== hdl/efsd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module efsd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic                                      rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== hdl/efsd_ctrl.sv =====
// Sequencer for the dispatch unit: accepts a job, walks the active servers,
// then steps the datapath through calculation and write-back.
// Depends on efsd_pkg.
module efsd_ctrl #(
   parameter int MAX_SERVERS = 16
) (
   input  logic                                           clock,
   input  logic                                           reset,
   input  logic                                           req_valid,
   output logic                                           req_ready,
   input  logic [efsd_pkg::ACT_W-1:0]                     active_servers,
   input  logic                                           out_free,
   output efsd_pkg::ctrl_cmd_type                         cmd,
   output logic [((MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1)-1:0] rd_addr
);
   import efsd_pkg::*;

   localparam int IDX_W = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_CALC,
      ST_COMMIT
   } state_type;

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] scan_idx_ff, scan_idx_in;
   logic [IDX_W-1:0] last_idx_ff, last_idx_in;
   logic             ready_ff, ready_in;
   logic [IDX_W-1:0] last_idx_cfg;
   logic             load;

   // Clamp the server count to 1..MAX_SERVERS and keep the last index
   always_comb begin
      if (active_servers == '0) begin
         last_idx_cfg = '0;
      end else if (32'(active_servers) > 32'(MAX_SERVERS)) begin
         last_idx_cfg = IDX_W'(MAX_SERVERS - 1);
      end else begin
         last_idx_cfg = IDX_W'(32'(active_servers) - 32'd1);
      end
   end

   assign load = req_valid && ready_ff;

   always_comb begin
      state_in    = state_ff;
      scan_idx_in = scan_idx_ff;
      last_idx_in = last_idx_ff;
      ready_in    = ready_ff;
      cmd         = '0;
      case (state_ff)
         ST_IDLE: begin
            if (load) begin
               cmd.load    = 1'b1;
               last_idx_in = last_idx_cfg;
               scan_idx_in = '0;
               ready_in    = 1'b0;
               state_in    = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.rd_en = 1'b1;
            if (scan_idx_ff == last_idx_ff) begin
               state_in = ST_DRAIN;
            end else begin
               scan_idx_in = scan_idx_ff + IDX_W'(1);
            end
         end
         ST_DRAIN: begin
            state_in = ST_CALC;
         end
         ST_CALC: begin
            cmd.calc = 1'b1;
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            // hold until the result register can take the beat
            if (out_free) begin
               cmd.commit = 1'b1;
               ready_in   = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
            ready_in = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         ready_ff    <= 1'b1;
         scan_idx_ff <= '0;
         last_idx_ff <= '0;
      end else begin
         state_ff    <= state_in;
         ready_ff    <= ready_in;
         scan_idx_ff <= scan_idx_in;
         last_idx_ff <= last_idx_in;
      end
   end

   assign req_ready = ready_ff;
   assign rd_addr   = scan_idx_ff;

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> scan_idx_ff <= last_idx_ff)
      else $error("scan index passed the last active server");

   a_ready_only_idle: assert property (@(posedge clock) disable iff (reset)
      ready_ff |-> state_ff == ST_IDLE)
      else $error("ready raised outside idle");
endmodule

// ===== hdl/efsd_dpath.sv =====
// Datapath of the dispatch unit: free-at RAM with valid bits, running
// minimum, late test, saturating finish time and count, result register.
// Depends on efsd_pkg, efsd_req_if, efsd_rsp_if and efsd_ram.
module efsd_dpath #(
   parameter int MAX_SERVERS = 16
) (
   input  logic                                           clock,
   input  logic                                           reset,
   efsd_req_if.sink                                       req,
   efsd_rsp_if.source                                     rsp,
   input  logic [efsd_pkg::WAIT_W-1:0]                    wait_limit,
   input  efsd_pkg::ctrl_cmd_type                         cmd,
   input  logic [((MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1)-1:0] rd_addr,
   output logic                                           out_free
);
   import efsd_pkg::*;

   localparam int IDX_W = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
   localparam logic [TIME_W-1:0] TIME_TOP = '1;

   logic [MAX_SERVERS-1:0] valid_ff;
   logic                   rd_pending_ff;
   logic [IDX_W-1:0]       rd_idx_ff;
   logic                   rd_vld_ff;
   logic [TIME_W-1:0]      ram_rd_data;
   logic [TIME_W-1:0]      entry;

   logic [TIME_W-1:0]      arrival_ff;
   logic [DUR_W-1:0]       duration_ff;
   logic [TIME_W-1:0]      min_ff, min_in;
   logic [IDX_W-1:0]       best_ff, best_in;
   logic [TIME_W-1:0]      start_ff;
   logic                   late_ff;
   logic [TIME_W-1:0]      late_cnt_ff, late_cnt_in;

   logic [TIME_W:0]        late_bound;
   logic [TIME_W:0]        finish_wide;
   logic [TIME_W-1:0]      finish;

   logic                   rsp_valid_ff;
   logic [TIME_W-1:0]      rsp_start_ff;
   logic                   rsp_late_ff;
   logic [TIME_W-1:0]      rsp_total_ff;

   efsd_ram #(
      .WIDTH (TIME_W),
      .DEPTH (MAX_SERVERS)
   ) u_free_at (
      .clock   (clock),
      .wr_en   (cmd.commit),
      .wr_addr (best_ff),
      .wr_data (finish),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (ram_rd_data)
   );

   // never-written entries read as zero
   assign entry = rd_vld_ff ? ram_rd_data : '0;

   // running minimum, strict compare keeps the lowest index on a tie
   always_comb begin
      min_in  = min_ff;
      best_in = best_ff;
      if (rd_pending_ff && ((rd_idx_ff == '0) || (entry < min_ff))) begin
         min_in  = entry;
         best_in = rd_idx_ff;
      end
   end

   assign late_bound  = {1'b0, arrival_ff} + {{(TIME_W + 1 - WAIT_W){1'b0}}, wait_limit};
   assign finish_wide = {1'b0, start_ff} + {{(TIME_W + 1 - DUR_W){1'b0}}, duration_ff};
   assign finish      = finish_wide[TIME_W] ? TIME_TOP : finish_wide[TIME_W-1:0];

   always_comb begin
      late_cnt_in = late_cnt_ff;
      if (cmd.commit && late_ff && (late_cnt_ff != TIME_TOP)) begin
         late_cnt_in = late_cnt_ff + TIME_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= '0;
         rd_pending_ff <= 1'b0;
         late_cnt_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rd_pending_ff <= cmd.rd_en;
         late_cnt_ff   <= late_cnt_in;
         if (cmd.commit) begin
            valid_ff[best_ff] <= 1'b1;
            rsp_valid_ff      <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff      <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff <= rd_addr;
      rd_vld_ff <= valid_ff[rd_addr];
      min_ff    <= min_in;
      best_ff   <= best_in;
      if (cmd.load) begin
         arrival_ff  <= req.arrival_time;
         duration_ff <= req.service_duration;
      end
      if (cmd.calc) begin
         late_ff  <= {1'b0, min_ff} > late_bound;
         start_ff <= (arrival_ff > min_ff) ? arrival_ff : min_ff;
      end
      if (cmd.commit) begin
         rsp_start_ff <= start_ff;
         rsp_late_ff  <= late_ff;
         rsp_total_ff <= late_cnt_in;
      end
   end

   assign out_free       = !rsp_valid_ff || rsp.ready;
   assign rsp.valid      = rsp_valid_ff;
   assign rsp.start_time = rsp_start_ff;
   assign rsp.late_flag  = rsp_late_ff;
   assign rsp.late_total = rsp_total_ff;

   a_commit_needs_room: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (!rsp_valid_ff || rsp.ready))
      else $error("result overwritten before it was taken");

   a_count_monotonic: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> late_cnt_ff >= $past(late_cnt_ff))
      else $error("late count went backwards");

   a_late_counted: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_late_ff |-> rsp_total_ff != '0)
      else $error("late result with zero late total");
endmodule

// ===== tb/tb_earliest_free_server_dispatch_unit.sv =====
`timescale 1ns / 1ps
// Self-checking bench for earliest_free_server_dispatch_unit: a directed table
// and then randomised job streams, checked against hand-written results or an in-bench dispatch model.
// Depends on efsd_pkg, efsd_req_if, efsd_rsp_if and the unit under test.
module tb_earliest_free_server_dispatch_unit;
   import efsd_pkg::*;

   localparam int MAX_SERVERS    = 16;
   localparam int DIRECTED_ROWS  = 22;
   localparam int RANDOM_PHASES  = 12;
   localparam int JOBS_PER_PHASE = 96;
   // Scan of every server plus drain, calc and write-back, with some slack.
   localparam int DRAIN_CYCLES   = MAX_SERVERS + 8;
   localparam int unsigned CYCLE_LIMIT = 600_000;
   localparam int REPORT_LIMIT   = 10;

   // Indexes the unit does not decode; writes to them must change nothing.
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 2'd3;

   typedef struct packed {
      logic [TIME_W-1:0] start_time;
      logic              late_flag;
      logic [TIME_W-1:0] late_total;
   } dispatch_result_type;

   typedef enum logic { ROW_JOB, ROW_CSR } row_kind_type;

   // One row of the directed table: a job beat or a register write. Rows with
   // fixed set carry a hand-written result; the rest take the model's.
   typedef struct packed {
      row_kind_type      kind;
      logic [TIME_W-1:0] arrival;
      logic [DUR_W-1:0]  duration;
      logic [CSR_IDX_W-1:0]  reg_idx;
      logic [CSR_DATA_W-1:0] reg_data;
      logic              fixed;
      logic [TIME_W-1:0] want_start;
      logic              want_late;
      logic [TIME_W-1:0] want_total;
   } stim_row_type;

   typedef enum logic [1:0] {
      SINK_OPEN, SINK_COIN, SINK_PERIODIC, SINK_HELD
   } sink_mode_type;

   logic clock;
   logic reset;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wr_data;

   efsd_req_if req_ch ();
   efsd_rsp_if rsp_ch ();

   earliest_free_server_dispatch_unit #(
      .MAX_SERVERS (MAX_SERVERS)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   // Dispatch model state: free-at times, late count and register copies.
   logic [TIME_W-1:0] server_free_at [MAX_SERVERS];
   logic [TIME_W-1:0] late_count;
   logic [ACT_W-1:0]  active_cfg;
   logic [WAIT_W-1:0] wait_cfg;

   dispatch_result_type pending_dispatches [$];

   int unsigned cycle_count = 0;
   int unsigned mismatch_count = 0;
   int unsigned jobs_sent = 0;
   int unsigned late_seen = 0;
   int unsigned csr_writes = 0;
   int unsigned burst_left = 0;

   sink_mode_type sink_mode = SINK_OPEN;
   int unsigned   sink_left = 0;
   int unsigned   sink_period = 2;

   // Directed rows. Opening rows run with one server, the reset wait limit
   // of 20 and every free-at time at zero.
   stim_row_type directed_rows [DIRECTED_ROWS] = '{
      // all fields at zero
      '{ROW_JOB, 32'h00000000, 16'h0000, '0, '0, 1'b1, 32'h00000000, 1'b0, 32'd0},
      // top arrival and duration: free-at saturates
      '{ROW_JOB, 32'hFFFFFFFF, 16'hFFFF, '0, '0, 1'b1, 32'hFFFFFFFF, 1'b0, 32'd0},
      // early arrival on a saturated server: late
      '{ROW_JOB, 32'h00000000, 16'h0005, '0, '0, 1'b1, 32'hFFFFFFFF, 1'b1, 32'd1},
      // arrival plus wait limit runs past 32 bits and must not wrap
      '{ROW_JOB, 32'hFFFFFFFF, 16'h0000, '0, '0, 1'b1, 32'hFFFFFFFF, 1'b0, 32'd1},
      // zero active servers behaves as one; upper data bits are dropped
      '{ROW_CSR, '0, '0, CSR_ACTIVE_SERVERS, 16'hFFE0, 1'b0, '0, 1'b0, '0},
      // wait exactly at the limit: not late
      '{ROW_JOB, 32'hFFFFFFEB, 16'h0001, '0, '0, 1'b1, 32'hFFFFFFFF, 1'b0, 32'd1},
      // one past the limit: late
      '{ROW_JOB, 32'hFFFFFFEA, 16'h0001, '0, '0, 1'b1, 32'hFFFFFFFF, 1'b1, 32'd2},
      // too many servers clamps to the maximum
      '{ROW_CSR, '0, '0, CSR_ACTIVE_SERVERS, 16'h001F, 1'b0, '0, 1'b0, '0},
      // ties on zero: lowest server wins, twice over
      '{ROW_JOB, 32'h00000064, 16'h0032, '0, '0, 1'b0, '0, 1'b0, '0},
      '{ROW_JOB, 32'h00000064, 16'h0032, '0, '0, 1'b0, '0, 1'b0, '0},
      '{ROW_CSR, '0, '0, CSR_WAIT_LIMIT, 16'h0000, 1'b0, '0, 1'b0, '0},
      '{ROW_JOB, 32'h00000000, 16'h0000, '0, '0, 1'b0, '0, 1'b0, '0},
      '{ROW_CSR, '0, '0, CSR_ACTIVE_SERVERS, 16'h0011, 1'b0, '0, 1'b0, '0},
      // undecoded indexes: writes ignored
      '{ROW_CSR, '0, '0, CSR_SPARE_LO, 16'hFFFF, 1'b0, '0, 1'b0, '0},
      '{ROW_CSR, '0, '0, CSR_SPARE_HI, 16'hFFFF, 1'b0, '0, 1'b0, '0},
      // shrink to two servers; the rest keep their free-at times
      '{ROW_CSR, '0, '0, CSR_ACTIVE_SERVERS, 16'h0002, 1'b0, '0, 1'b0, '0},
      '{ROW_JOB, 32'h0000000A, 16'h0007, '0, '0, 1'b0, '0, 1'b0, '0},
      '{ROW_JOB, 32'h000000C8, 16'h0001, '0, '0, 1'b0, '0, 1'b0, '0},
      '{ROW_CSR, '0, '0, CSR_WAIT_LIMIT, 16'hFFFF, 1'b0, '0, 1'b0, '0},
      // widen again: the parked servers are scanned once more
      '{ROW_CSR, '0, '0, CSR_ACTIVE_SERVERS, 16'h0010, 1'b0, '0, 1'b0, '0},
      '{ROW_JOB, 32'h00000005, 16'hFFFF, '0, '0, 1'b0, '0, 1'b0, '0},
      '{ROW_JOB, 32'h00000000, 16'h0000, '0, '0, 1'b0, '0, 1'b0, '0}
   };

   initial clock = 1'b0;
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   // ---------------------------------------------------------------------
   // Dispatch model
   // ---------------------------------------------------------------------

   // Saturating add on the time scale.
   function automatic logic [TIME_W-1:0] time_advance(input logic [TIME_W-1:0] base,
                                                       input int unsigned step);
      logic [TIME_W:0] sum;
      sum = {1'b0, base} + (TIME_W+1)'(step);
      return sum[TIME_W] ? '1 : sum[TIME_W-1:0];
   endfunction

   // Clamp the register to 1..MAX_SERVERS.
   function automatic int unsigned live_servers();
      int unsigned n;
      n = active_cfg;
      if (n < 1) n = 1;
      if (n > MAX_SERVERS) n = MAX_SERVERS;
      return n;
   endfunction

   // Lowest-numbered live server holding the smallest free-at time.
   function automatic int unsigned earliest_server();
      int unsigned best;
      best = 0;
      for (int unsigned i = 1; i < live_servers(); i++) begin
         if (server_free_at[i] < server_free_at[best]) best = i;
      end
      return best;
   endfunction

   // Place one job, advance the model and return the result it must produce.
   function automatic dispatch_result_type dispatch_to_server(
         input logic [TIME_W-1:0] arrival, input logic [DUR_W-1:0] duration);
      int unsigned         best;
      logic [TIME_W-1:0]   chosen;
      dispatch_result_type res;
      best   = earliest_server();
      chosen = server_free_at[best];
      // Compare with one extra bit so arrival plus limit never wraps.
      res.late_flag = {1'b0, chosen} > ({1'b0, arrival} + (TIME_W+1)'(wait_cfg));
      if (res.late_flag && late_count != '1) late_count = late_count + 1;
      res.start_time = (arrival > chosen) ? arrival : chosen;
      res.late_total = late_count;
      server_free_at[best] = time_advance(res.start_time, duration);
      return res;
   endfunction

   function automatic void apply_csr(input logic [CSR_IDX_W-1:0] reg_idx,
                                     input logic [CSR_DATA_W-1:0] reg_data);
      case (reg_idx)
         CSR_ACTIVE_SERVERS: active_cfg = reg_data[ACT_W-1:0];
         CSR_WAIT_LIMIT:     wait_cfg   = reg_data[WAIT_W-1:0];
         default: ;
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // Sender
   // ---------------------------------------------------------------------

   // Bursts of back-to-back beats, split by gaps of random length; now and
   // then a long gap so the next beat lands late in the scan.
   function automatic int unsigned next_gap();
      if (burst_left != 0) begin
         burst_left--;
         return 0;
      end
      burst_left = $urandom_range(0, 23);
      if ($urandom_range(0, 3) == 0) return $urandom_range(0, 60);
      return $urandom_range(1, 12);
   endfunction

   // Drive one job beat, hold it until taken, then queue what it must yield.
   // A fixed row overrides the modelled result; the model still advances.
   task automatic send_job(input logic [TIME_W-1:0] arrival, input logic [DUR_W-1:0] duration,
                           input int unsigned gap, input logic fixed,
                           input dispatch_result_type fixed_result);
      dispatch_result_type modelled;
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid            <= 1'b1;
      req_ch.arrival_time     <= arrival;
      req_ch.service_duration <= duration;
      do @(posedge clock); while (!req_ch.ready);
      modelled = dispatch_to_server(arrival, duration);
      pending_dispatches.push_back(fixed ? fixed_result : modelled);
      jobs_sent++;
   endtask

   // Drop valid and hold until every result is back.
   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      while (pending_dispatches.size() != 0) @(posedge clock);
   endtask

   // Register writes only while the unit is idle.
   task automatic write_csr(input logic [CSR_IDX_W-1:0] reg_idx,
                            input logic [CSR_DATA_W-1:0] reg_data);
      wait_idle();
      csr_wr_en   <= 1'b1;
      csr_index   <= reg_idx;
      csr_wr_data <= reg_data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      apply_csr(reg_idx, reg_data);
      csr_writes++;
      // leave the write enable low before the next write starts
      @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Receiver: segments of free flow, coin-toss stalls, periodic ready and
   // solid stalls, each segment of random length.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (sink_left == 0) begin
         sink_mode   = sink_mode_type'($urandom_range(0, 3));
         sink_left   = (sink_mode == SINK_HELD) ? $urandom_range(1, 40)
                                                : $urandom_range(10, 150);
         sink_period = $urandom_range(2, 8);
      end else begin
         sink_left--;
      end
      case (sink_mode)
         SINK_OPEN:     rsp_ch.ready <= 1'b1;
         SINK_COIN:     rsp_ch.ready <= 1'($urandom_range(0, 1));
         SINK_PERIODIC: rsp_ch.ready <= (sink_left % sink_period) == 0;
         default:       rsp_ch.ready <= 1'b0;
      endcase
   end

   // ---------------------------------------------------------------------
   // Result checker: compare each result beat with the oldest expectation.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      dispatch_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (rsp_ch.late_flag) late_seen++;
         if (pending_dispatches.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("[%0t] result beat with no job pending: start %h late %b total %0d",
                        $realtime, rsp_ch.start_time, rsp_ch.late_flag, rsp_ch.late_total);
         end else begin
            want = pending_dispatches.pop_front();
            if (rsp_ch.start_time !== want.start_time || rsp_ch.late_flag !== want.late_flag ||
                rsp_ch.late_total !== want.late_total) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("[%0t] mismatch (exp/act): start %h/%h late %b/%b total %0d/%0d",
                           $realtime, want.start_time, rsp_ch.start_time, want.late_flag,
                           rsp_ch.late_flag, want.late_total, rsp_ch.late_total);
            end
         end
      end
   end

   // Watchdog: a hung handshake ends the run here.
   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("end of test: mismatches");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      logic [CSR_DATA_W-1:0] act_data;
      logic [CSR_DATA_W-1:0] wait_data;
      logic [TIME_W-1:0]     stream_time;
      logic [TIME_W-1:0]     arrival;
      logic [DUR_W-1:0]      duration;
      int unsigned           dur_span;
      int unsigned           backoff;
      int unsigned           pick;

      // Initialise every input before the first edge.
      reset                   = 1'b1;
      req_ch.valid            = 1'b0;
      req_ch.arrival_time     = '0;
      req_ch.service_duration = '0;
      rsp_ch.ready            = 1'b0;
      csr_wr_en               = 1'b0;
      csr_index               = CSR_ACTIVE_SERVERS;
      csr_wr_data             = '0;

      for (int i = 0; i < MAX_SERVERS; i++) server_free_at[i] = '0;
      late_count = '0;
      active_cfg = ACTIVE_RESET;
      wait_cfg   = WAIT_RESET;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Walk the directed table.
      for (int row = 0; row < DIRECTED_ROWS; row++) begin
         if (directed_rows[row].kind == ROW_CSR)
            write_csr(directed_rows[row].reg_idx, directed_rows[row].reg_data);
         else
            send_job(directed_rows[row].arrival, directed_rows[row].duration, next_gap(),
                     directed_rows[row].fixed,
                     '{directed_rows[row].want_start, directed_rows[row].want_late,
                       directed_rows[row].want_total});
      end

      // Random phases: each gets its own server count and wait limit, the
      // first few at the extremes, then a job stream near full load.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         act_data  = 16'($urandom_range(0, 16'hFFFF));
         wait_data = 16'($urandom_range(0, (1 << $urandom_range(0, 16)) - 1));
         case (phase)
            0: begin act_data[ACT_W-1:0] = ACT_W'(1);  wait_data = '0; end
            1: begin act_data[ACT_W-1:0] = ACT_W'(MAX_SERVERS); wait_data = '1; end
            2: act_data[ACT_W-1:0] = '0;
            3: act_data[ACT_W-1:0] = '1;
            default:
               if ($urandom_range(0, 4) != 0)
                  act_data[ACT_W-1:0] = ACT_W'($urandom_range(1, MAX_SERVERS));
         endcase
         write_csr(CSR_ACTIVE_SERVERS, act_data);
         write_csr(CSR_WAIT_LIMIT, wait_data);
         if ($urandom_range(0, 3) == 0)
            write_csr($urandom_range(0, 1) ? CSR_SPARE_HI : CSR_SPARE_LO,
                      16'($urandom_range(0, 16'hFFFF)));

         // Start the stream a little behind the earliest server so some
         // jobs queue and, with a tight limit, run late.
         dur_span    = $urandom_range(1, 300);
         backoff     = $urandom_range(0, 300);
         stream_time = server_free_at[earliest_server()];
         stream_time = (stream_time > backoff) ? stream_time - backoff : '0;

         for (int j = 0; j < JOBS_PER_PHASE; j++) begin
            pick = $urandom_range(0, 99);
            if (pick < 90) begin
               // Ordered arrivals, spacing matched to the server count.
               stream_time = time_advance(stream_time,
                                          $urandom_range(0, 2 * dur_span / live_servers() + 1));
               arrival  = stream_time;
               duration = DUR_W'($urandom_range(0, 2 * dur_span));
            end else if (pick < 96) begin
               // Noise: any arrival, any duration.
               arrival  = $urandom;
               duration = DUR_W'($urandom_range(0, 16'hFFFF));
            end else begin
               // Near the top of the time range: saturation.
               arrival  = 32'hFFFFFFFF - $urandom_range(0, 70000);
               duration = DUR_W'($urandom_range(0, 16'hFFFF));
            end
            send_job(arrival, duration, next_gap(), 1'b0, '0);
         end
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d directed rows and %0d random phases: %0d jobs, %0d register writes",
               DIRECTED_ROWS, RANDOM_PHASES, jobs_sent, csr_writes);
      $display("late results seen: %0d, final late count %0d, failures %0d",
               late_seen, late_count, mismatch_count);
      if (mismatch_count == 0 && pending_dispatches.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
